### rtl/rcs_pkg.sv
// ----------------------------------------------------------------------------
// Running column statistics package
// Shared constants and item kind codes for the statistics block.
// ----------------------------------------------------------------------------
package rcs_pkg;

    localparam int SAMPLE_WIDTH_DEF = 24;
    localparam int COUNT_WIDTH_DEF  = 16;

    localparam logic [1:0] KIND_NULL   = 2'd0;
    localparam logic [1:0] KIND_NUMBER = 2'd1;
    localparam logic [1:0] KIND_STRING = 2'd2;

endpackage

### rtl/rcs_if.sv
// ----------------------------------------------------------------------------
// Valid/ready channel
// Carries one payload of width W between a source and a sink.
// ----------------------------------------------------------------------------
interface rcs_if #(
    parameter int W = 8
);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/running_column_statistics.sv
// ----------------------------------------------------------------------------
// Running column statistics
// Keeps count, sum, sum of squares, extremes and order flags of a column and
// reports mean and sample standard deviation after every item.
// ----------------------------------------------------------------------------
// Each accepted item yields one result, and the block is not ready again until
// that result has been taken. The time from acceptance to result depends on how
// many numbers are stored after the item is applied. With none stored, no division
// is run. With one stored, the mean division is added. With two or more stored,
// the N*sqsum product, the sum^2 subtraction, the variance division and the
// square root follow. A number item first has its square formed. The single
// shared one-bit-per-cycle divide/square root unit sets most of this time; the
// products are formed by shift-and-add into one accumulator.
module running_column_statistics #(
    parameter int SAMPLE_WIDTH = rcs_pkg::SAMPLE_WIDTH_DEF,
    parameter int COUNT_WIDTH  = rcs_pkg::COUNT_WIDTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    rcs_if.sink   in_ch,
    rcs_if.source out_ch
);
    localparam int SW  = SAMPLE_WIDTH;
    localparam int CW  = COUNT_WIDTH;
    localparam int TW  = SW + CW;           // output total width
    localparam int QW  = 2 * SW + CW;       // square sum width
    localparam int PW  = 2 * (SW + CW) + 2; // variance numerator width
    localparam int OW  = 5 * SW + 4 * CW + 3;
    localparam int IW  = $clog2(PW + 1);
    localparam logic [CW-1:0] CMAX = '1;

    localparam logic [3:0] S_IDLE = 4'd0, S_SQ = 4'd1, S_UPD = 4'd2,
        S_MEAN = 4'd3, S_MWAIT = 4'd4, S_P1 = 4'd5, S_P2 = 4'd6,
        S_VDIV = 4'd7, S_VWAIT = 4'd8, S_RT = 4'd9, S_RWAIT = 4'd10,
        S_OUT = 4'd11;

    logic [3:0]        r_st;
    logic [1:0]        r_kind;
    logic signed [SW-1:0] r_x, r_min, r_max, r_prev, r_mean;
    logic signed [TW:0]   r_sum;
    logic [QW-1:0]     r_sq;
    logic [CW-1:0]     r_cnt, r_nul, r_str;
    logic              r_nasc, r_ndesc, r_drop;
    logic [PW-1:0]     r_acc, r_mc;
    logic [SW+CW:0]    r_mul;
    logic [IW-1:0]     r_i;
    logic [SW-2:0]     r_dev;
    logic              r_dvv;
    logic              r_ov;
    logic [OW-1:0]     r_out;

    logic [SW+CW:0] w_msum;
    logic [SW-1:0]  w_mx;
    logic           w_start, w_sqrt, w_done;
    logic [PW-1:0]  w_num, w_quot;
    logic [2*CW-1:0] w_den;
    logic [PW/2-1:0] w_root;

    assign w_msum = r_sum[TW] ? (SW+CW+1)'(-r_sum) : (SW+CW+1)'(r_sum);
    assign w_mx   = r_x[SW-1] ? SW'(-r_x) : SW'(r_x);

    rcs_divsqrt #(.NW(PW), .DW(2 * CW), .RW(PW / 2)) u_unit (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_start), .i_sqrt(w_sqrt),
        .i_num(w_num), .i_den(w_den), .o_done(w_done), .o_quot(w_quot),
        .o_root(w_root)
    );

    always_comb begin
        w_start = (r_st == S_MEAN) || (r_st == S_VDIV) || (r_st == S_RT);
        w_sqrt  = (r_st == S_RT);
        w_num   = (r_st == S_MEAN) ? PW'(w_msum) : r_acc;
        w_den   = (r_st == S_MEAN) ? (2*CW)'(r_cnt)
                                   : (2*CW)'(r_cnt) * (2*CW)'(r_cnt - 1'b1);
    end

    assign in_ch.ready  = (r_st == S_IDLE) && !r_ov;
    assign out_ch.valid = r_ov;
    assign out_ch.data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_ov <= 1'b0;
            r_min <= '0; r_max <= '0; r_prev <= '0; r_sum <= '0; r_sq <= '0;
            r_cnt <= '0; r_nul <= '0; r_str <= '0;
            r_nasc <= 1'b0; r_ndesc <= 1'b0; r_drop <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) r_ov <= 1'b0;
            case (r_st)
                S_IDLE: begin
                    if (in_ch.valid && !r_ov) begin
                        r_kind <= in_ch.data[1:0];
                        r_x    <= in_ch.data[SW+1:2];
                        r_st   <= S_SQ;
                        r_acc  <= '0;
                        r_i    <= '0;
                    end
                end
                S_SQ: begin
                    // Square of the magnitude, one multiplier bit per cycle.
                    if (r_kind == rcs_pkg::KIND_NUMBER && r_i != IW'(SW)) begin
                        if (w_mx[r_i[$clog2(SW)-1+1-1:0]])
                            r_acc <= r_acc + (PW'(w_mx) << r_i);
                        r_i <= r_i + 1'b1;
                    end else begin
                        r_st <= S_UPD;
                    end
                end
                S_UPD: begin
                    case (r_kind)
                        rcs_pkg::KIND_NULL:   if (r_nul != CMAX) r_nul <= r_nul + 1'b1;
                        rcs_pkg::KIND_STRING: if (r_str != CMAX) r_str <= r_str + 1'b1;
                        rcs_pkg::KIND_NUMBER: begin
                            if (r_cnt == CMAX) r_drop <= 1'b1;
                            else begin
                                r_sum <= r_sum + (TW+1)'(r_x);
                                r_sq  <= r_sq + QW'(r_acc);
                                if (r_cnt == '0 || r_x < r_min) r_min <= r_x;
                                if (r_cnt == '0 || r_x > r_max) r_max <= r_x;
                                if (r_cnt != '0) begin
                                    if (r_prev > r_x) r_nasc  <= 1'b1;
                                    if (r_prev < r_x) r_ndesc <= 1'b1;
                                end
                                r_prev <= r_x;
                                r_cnt  <= r_cnt + 1'b1;
                            end
                        end
                        default: ;
                    endcase
                    r_st <= S_MEAN;
                end
                S_MEAN: begin
                    r_mean <= '0;
                    r_dev  <= '0;
                    r_dvv  <= (r_cnt > CW'(1));
                    r_st   <= (r_cnt == '0) ? S_OUT : S_MWAIT;
                end
                S_MWAIT: begin
                    if (w_done) begin
                        r_mean <= r_sum[TW] ? SW'(-w_quot) : SW'(w_quot);
                        r_acc  <= '0;
                        r_mc   <= PW'(r_sq);
                        r_mul  <= (SW+CW+1)'(r_cnt);
                        r_i    <= '0;
                        r_st   <= (r_cnt > CW'(1)) ? S_P1 : S_OUT;
                    end
                end
                S_P1: begin
                    // N * sqsum, one count bit per cycle.
                    if (r_i != IW'(CW)) begin
                        if (r_mul[0]) r_acc <= r_acc + r_mc;
                        r_mc  <= r_mc << 1;
                        r_mul <= r_mul >> 1;
                        r_i   <= r_i + 1'b1;
                    end else begin
                        r_mc  <= PW'(w_msum);
                        r_mul <= w_msum;
                        r_i   <= '0;
                        r_st  <= S_P2;
                    end
                end
                S_P2: begin
                    // Subtract sum^2, one bit of |sum| per cycle.
                    if (r_i != IW'(SW + CW + 1)) begin
                        if (r_mul[0]) r_acc <= r_acc - r_mc;
                        r_mc  <= r_mc << 1;
                        r_mul <= r_mul >> 1;
                        r_i   <= r_i + 1'b1;
                    end else begin
                        r_st <= S_VDIV;
                    end
                end
                S_VDIV: r_st <= S_VWAIT;
                S_VWAIT: begin
                    if (w_done) begin
                        r_acc <= w_quot;
                        r_st  <= S_RT;
                    end
                end
                S_RT: r_st <= S_RWAIT;
                S_RWAIT: begin
                    if (w_done) begin
                        if (w_root > (PW/2)'({(SW-1){1'b1}})) r_dev <= '1;
                        else r_dev <= (SW-1)'(w_root);
                        r_st <= S_OUT;
                    end
                end
                S_OUT: begin
                    r_out <= {r_drop, r_dvv, r_dev, r_mean, ~r_ndesc, ~r_nasc,
                              r_str, r_nul, r_cnt, r_sum[TW-1:0], r_max, r_min};
                    r_ov  <= 1'b1;
                    r_st  <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule

### rtl/rcs_divsqrt.sv
// ----------------------------------------------------------------------------
// Shared divide and square root unit
// Restoring division and digit-by-digit square root, one bit per cycle on a
// single shared subtractor.
// ----------------------------------------------------------------------------
module rcs_divsqrt #(
    parameter int NW = 80,
    parameter int DW = 40,
    parameter int RW = 40
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic          i_sqrt,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_done,
    output logic [NW-1:0] o_quot,
    output logic [RW-1:0] o_root
);
    localparam int CW = $clog2(NW + 1);
    localparam int AW = NW + 2;

    logic          r_busy, r_sqrt;
    logic [CW-1:0] r_cnt;
    logic [NW-1:0] r_n, r_q;
    logic [DW-1:0] r_den;
    logic [AW-1:0] r_rem;
    logic [AW-1:0] w_shift, w_sub, w_try;
    logic          w_ok;

    // Division shifts one numerator bit per step; square root takes two.
    // The divisor is held from the start so the caller may change it.
    always_comb begin
        if (r_sqrt) begin
            w_shift = {r_rem[AW-3:0], r_n[NW-1:NW-2]};
            w_try   = {r_q[AW-3:0], 2'b01};
        end else begin
            w_shift = {r_rem[AW-2:0], r_n[NW-1]};
            w_try   = AW'(r_den);
        end
        w_ok  = (w_shift >= w_try);
        w_sub = w_shift - w_try;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_sqrt <= i_sqrt;
                r_cnt  <= i_sqrt ? CW'(NW / 2) : CW'(NW);
                r_n    <= i_num;
                r_den  <= i_den;
                r_q    <= '0;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_rem <= w_ok ? w_sub : w_shift;
                r_q   <= {r_q[NW-2:0], w_ok};
                r_n   <= r_sqrt ? {r_n[NW-3:0], 2'b00} : {r_n[NW-2:0], 1'b0};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    assign o_quot = r_q;
    assign o_root = r_q[RW-1:0];
endmodule

### dv/running_column_statistics_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Running column statistics testbench
// Feeds nulls, strings, numbers and unused kinds into the block, predicts
// every statistics result on its own and compares each result field by field.
// ----------------------------------------------------------------------------
module running_column_statistics_tb;

    localparam int SW = rcs_pkg::SAMPLE_WIDTH_DEF;
    localparam int CW = rcs_pkg::COUNT_WIDTH_DEF;
    localparam int WATCHDOG_LIMIT = 6000;
    localparam int RANDOM_ITEMS = 490;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    // Field order follows the block's packing, first field in the high bits.
    typedef struct packed {
        logic [SW-1:0] sample;
        logic [1:0]    kind;
    } column_item_t;

    typedef struct packed {
        logic             overflow;
        logic             deviation_valid;
        logic [SW-2:0]    deviation;
        logic [SW-1:0]    mean;
        logic             descending;
        logic             ascending;
        logic [CW-1:0]    string_count;
        logic [CW-1:0]    null_count;
        logic [CW-1:0]    number_count;
        logic [SW+CW-1:0] total;
        logic [SW-1:0]    maximum;
        logic [SW-1:0]    minimum;
    } column_stats_t;

    typedef struct {
        logic [1:0]    kind;
        logic [SW-1:0] sample;
        bit            known;
        column_stats_t stats;
    } stimulus_row_t;

    logic i_clk;
    logic i_rst_n;

    rcs_if #(.W($bits(column_item_t)))  in_ch ();
    rcs_if #(.W($bits(column_stats_t))) out_ch ();

    running_column_statistics dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Private copy of the column state used for prediction.
    longint          col_min, col_max, col_prev, col_sum;
    logic [127:0]    col_square_sum;
    int unsigned     col_count, col_nulls, col_strings;
    bit              col_not_up, col_not_down, col_dropped;

    column_stats_t   expected_stats_q[$];
    bit              typed_known_q[$];
    column_stats_t   typed_stats_q[$];

    int  mismatch_count;
    int  idle_cycles;
    bit  long_holdoff;
    bit  no_idling;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $time);
        mismatch_count++;
    endtask

    function automatic logic [63:0] floor_sqrt(input logic [127:0] v);
        logic [63:0]  r;
        logic [63:0]  c;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            c = r | (64'd1 << b);
            if ({64'd0, c} * {64'd0, c} <= v) r = c;
        end
        return r;
    endfunction

    // Applies one item to the private state and returns the statistics after it.
    function automatic column_stats_t update_column(input logic [1:0] kind,
                                                    input logic [SW-1:0] sample);
        column_stats_t s;
        longint        x;
        longint        mean_value;
        logic [127:0]  mag;
        logic [127:0]  spread;
        logic [63:0]   dev;
        x = longint'($signed(sample));
        if (kind == rcs_pkg::KIND_NULL) begin
            if (col_nulls < (1 << CW) - 1) col_nulls++;
        end else if (kind == rcs_pkg::KIND_STRING) begin
            if (col_strings < (1 << CW) - 1) col_strings++;
        end else if (kind == rcs_pkg::KIND_NUMBER) begin
            if (col_count >= (1 << CW) - 1) begin
                col_dropped = 1'b1;
            end else begin
                mag = (x < 0) ? 128'(-x) : 128'(x);
                col_sum += x;
                col_square_sum += mag * mag;
                if (col_count == 0 || x < col_min) col_min = x;
                if (col_count == 0 || x > col_max) col_max = x;
                if (col_count != 0) begin
                    if (col_prev > x) col_not_up = 1'b1;
                    if (col_prev < x) col_not_down = 1'b1;
                end
                col_prev = x;
                col_count++;
            end
        end
        mean_value = (col_count != 0) ? col_sum / longint'(col_count) : 0;
        dev = '0;
        if (col_count >= 2) begin
            mag = (col_sum < 0) ? 128'(-col_sum) : 128'(col_sum);
            spread = col_square_sum * 128'(col_count) - mag * mag;
            spread = spread / (128'(col_count) * 128'(col_count - 1));
            dev = floor_sqrt(spread);
            if (dev > (64'd1 << (SW - 1)) - 1) dev = (64'd1 << (SW - 1)) - 1;
        end
        s.minimum         = col_min[SW-1:0];
        s.maximum         = col_max[SW-1:0];
        s.total           = col_sum[SW+CW-1:0];
        s.number_count    = col_count[CW-1:0];
        s.null_count      = col_nulls[CW-1:0];
        s.string_count    = col_strings[CW-1:0];
        s.ascending       = ~col_not_up;
        s.descending      = ~col_not_down;
        s.mean            = mean_value[SW-1:0];
        s.deviation       = dev[SW-2:0];
        s.deviation_valid = col_count >= 2;
        s.overflow        = col_dropped;
        return s;
    endfunction

    task automatic compare_stats(input string tag, input column_stats_t got,
                                 input column_stats_t want);
        if (got.minimum !== want.minimum)
            report_mismatch({tag, " minimum"}, got.minimum, want.minimum);
        if (got.maximum !== want.maximum)
            report_mismatch({tag, " maximum"}, got.maximum, want.maximum);
        if (got.total !== want.total)
            report_mismatch({tag, " total"}, got.total, want.total);
        if (got.number_count !== want.number_count)
            report_mismatch({tag, " number_count"}, got.number_count, want.number_count);
        if (got.null_count !== want.null_count)
            report_mismatch({tag, " null_count"}, got.null_count, want.null_count);
        if (got.string_count !== want.string_count)
            report_mismatch({tag, " string_count"}, got.string_count, want.string_count);
        if (got.ascending !== want.ascending)
            report_mismatch({tag, " ascending"}, got.ascending, want.ascending);
        if (got.descending !== want.descending)
            report_mismatch({tag, " descending"}, got.descending, want.descending);
        if (got.mean !== want.mean)
            report_mismatch({tag, " mean"}, got.mean, want.mean);
        if (got.deviation !== want.deviation)
            report_mismatch({tag, " deviation"}, got.deviation, want.deviation);
        if (got.deviation_valid !== want.deviation_valid)
            report_mismatch({tag, " deviation_valid"}, got.deviation_valid,
                            want.deviation_valid);
        if (got.overflow !== want.overflow)
            report_mismatch({tag, " overflow"}, got.overflow, want.overflow);
    endtask

    // Input monitor: every accepted item gets its predicted result queued.
    always @(posedge i_clk) begin
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            column_item_t it;
            it = in_ch.data;
            expected_stats_q.push_back(update_column(it.kind, it.sample));
        end
    end

    // Output monitor: compare each accepted result with the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            column_stats_t got;
            got = out_ch.data;
            if (expected_stats_q.size() == 0) begin
                $display("MISMATCH: result with nothing expected at %0t", $time);
                mismatch_count++;
            end else begin
                compare_stats("stats", got, expected_stats_q.pop_front());
                if (typed_known_q.size() != 0) begin
                    if (typed_known_q.pop_front())
                        compare_stats("table", got, typed_stats_q.pop_front());
                    else
                        void'(typed_stats_q.pop_front());
                end
            end
        end
    end

    // Watchdog on cycles without any handshake on either side.
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Receiver: random stall bursts, one long hold-off, none near the end.
    initial begin
        out_ch.ready = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (long_holdoff) begin
                out_ch.ready <= 1'b0;
                repeat (600) @(posedge i_clk);
                long_holdoff = 1'b0;
            end else if (!no_idling && $urandom_range(0, 3) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge i_clk);
            end else begin
                out_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge i_clk);
            end
        end
    end

    // Offers one item and holds it until the block takes it.
    task automatic send_item(input logic [1:0] kind, input logic [SW-1:0] sample);
        column_item_t it;
        if (!no_idling && $urandom_range(0, 3) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        it.kind   = kind;
        it.sample = sample;
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    function automatic logic [SW-1:0] random_sample();
        case ($urandom_range(0, 5))
            0: return {1'b0, {(SW-1){1'b1}}};
            1: return {1'b1, {(SW-1){1'b0}}};
            2: return SW'($signed($urandom_range(0, 8192)) - 4096);
            default: return SW'($urandom);
        endcase
    endfunction

    stimulus_row_t table_rows[$];

    function automatic stimulus_row_t row(input logic [1:0] k, input logic [SW-1:0] v);
        stimulus_row_t r;
        r.kind = k;
        r.sample = v;
        r.known = 1'b0;
        r.stats = '0;
        return r;
    endfunction

    initial begin
        stimulus_row_t r;
        logic [1:0]    kind;
        logic [SW-1:0] base;
        int            pick;
        mismatch_count = 0;
        idle_cycles = 0;
        long_holdoff = 1'b0;
        no_idling = 1'b0;
        col_min = 0; col_max = 0; col_prev = 0; col_sum = 0;
        col_square_sum = '0;
        col_count = 0; col_nulls = 0; col_strings = 0;
        col_not_up = 1'b0; col_not_down = 1'b0; col_dropped = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        i_rst_n = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty column after a null: everything zero, both orders hold.
        r = row(rcs_pkg::KIND_NULL, '0);
        r.known = 1'b1;
        r.stats.null_count = 1;
        r.stats.ascending = 1'b1;
        r.stats.descending = 1'b1;
        table_rows.push_back(r);
        // A string and an unused kind leave the numbers untouched.
        r = row(rcs_pkg::KIND_STRING, {SW{1'b1}});
        r.known = 1'b1;
        r.stats.null_count = 1;
        r.stats.string_count = 1;
        r.stats.ascending = 1'b1;
        r.stats.descending = 1'b1;
        table_rows.push_back(r);
        table_rows.push_back(row(KIND_UNUSED, {SW{1'b1}}));
        // A single number: no deviation yet.
        table_rows.push_back(row(rcs_pkg::KIND_NUMBER, SW'(4096)));
        table_rows.push_back(row(rcs_pkg::KIND_NUMBER, SW'(4096)));
        table_rows.push_back(row(rcs_pkg::KIND_NUMBER, {1'b0, {(SW-1){1'b1}}}));
        table_rows.push_back(row(rcs_pkg::KIND_NUMBER, {1'b1, {(SW-1){1'b0}}}));
        table_rows.push_back(row(rcs_pkg::KIND_NUMBER, {1'b0, {(SW-1){1'b1}}}));
        table_rows.push_back(row(rcs_pkg::KIND_NUMBER, {1'b1, {(SW-1){1'b0}}}));
        table_rows.push_back(row(rcs_pkg::KIND_NUMBER, '0));
        table_rows.push_back(row(rcs_pkg::KIND_NUMBER, {SW{1'b1}}));
        table_rows.push_back(row(rcs_pkg::KIND_NULL, SW'(5)));
        table_rows.push_back(row(rcs_pkg::KIND_STRING, '0));
        table_rows.push_back(row(KIND_UNUSED, '0));
        table_rows.push_back(row(rcs_pkg::KIND_NUMBER, SW'(-12288)));

        foreach (table_rows[i]) begin
            typed_known_q.push_back(table_rows[i].known);
            typed_stats_q.push_back(table_rows[i].stats);
            send_item(table_rows[i].kind, table_rows[i].sample);
        end

        // Random part: mostly runs of numbers, some ordered, mixed with the rest.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == 100) long_holdoff = 1'b1;
            if (n == 300) begin
                in_ch.valid <= 1'b0;
                @(posedge i_clk);
                wait (expected_stats_q.size() == 0);
                @(posedge i_clk);
            end
            if (n == RANDOM_ITEMS - 60) no_idling = 1'b1;
            pick = $urandom_range(0, 9);
            if (pick < 6) begin
                kind = rcs_pkg::KIND_NUMBER;
            end else if (pick == 6) begin
                kind = rcs_pkg::KIND_NULL;
            end else if (pick == 7) begin
                kind = rcs_pkg::KIND_STRING;
            end else if (pick == 8) begin
                kind = KIND_UNUSED;
            end else begin
                // Short ordered run keeps one order flag alive for a while.
                base = SW'($urandom_range(0, 1000));
                for (int k = 0; k < 4; k++) begin
                    send_item(rcs_pkg::KIND_NUMBER, base);
                    base = base + SW'($urandom_range(0, 50));
                end
                continue;
            end
            send_item(kind, random_sample());
        end

        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        wait (expected_stats_q.size() == 0);
        repeat (400) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
